// ===== rtl/core/tspa_pkg.sv =====
// Shared types and constants for the TS packet aligner and sync tracker.
// No dependencies; every other file in rtl/core imports this package.
package tspa_pkg;

  // Transport stream framing constants.
  localparam logic [7:0]  SyncByte = 8'h47;
  localparam logic [7:0]  PktLen   = 8'd188;
  localparam logic [7:0]  PktLast  = 8'd187;
  localparam logic [15:0] PktLenW  = 16'd188;

  // Configuration register reset values.
  localparam logic       SyncEnableRst    = 1'b1;
  localparam logic [3:0] LockThresholdRst = 4'd5;
  localparam logic [3:0] LossThresholdRst = 4'd2;

  // Configuration register indexes (paddr[3:2]).
  localparam logic [1:0] RegSyncEnable    = 2'd0;
  localparam logic [1:0] RegLockThreshold = 2'd1;
  localparam logic [1:0] RegLossThreshold = 2'd2;

  // Aligner modes, one-hot.
  typedef enum logic [3:0] {
    ModeIdle   = 4'b0001,
    ModePass   = 4'b0010,
    ModeGather = 4'b0100,
    ModeSkip   = 4'b1000
  } mode_e;

  // Packet boundary event sent from the aligner to the lock tracker.
  typedef struct packed {
    logic valid;
    logic ok;
  } boundary_t;

  // Per-byte result of the aligner.
  typedef struct packed {
    logic       emit;
    logic [7:0] idx;
    logic       last;
    logic       hbad;
  } align_res_t;

  // Tracking configuration.
  typedef struct packed {
    logic       sync_enable;
    logic [3:0] lock_threshold;
    logic [3:0] loss_threshold;
  } track_cfg_t;

  // Tracking status after the current step.
  typedef struct packed {
    logic        locked;
    logic [31:0] err_cnt;
    logic [31:0] loss_cnt;
  } track_stat_t;

endpackage

// ===== rtl/core/tspa_align.sv =====
// Packet aligner: mode, position and first-byte flag, one byte per step.
// Depends on tspa_pkg; feeds boundary events to tspa_lock_track.
module tspa_align import tspa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  input  logic [15:0] left_i,
  output boundary_t   bnd_o,
  output align_res_t  res_o
);

  mode_e      mode_q, mode_d;
  logic [7:0] pos_q, pos_d;
  logic       fbb_q, fbb_d;

  logic       is_sync;
  logic       start;
  logic       mode_gather;
  logic       fbb_eff;
  logic [7:0] idx;

  assign is_sync = (byte_i == SyncByte);

  // Step logic: skip, packet start, then the byte itself.
  always_comb begin
    mode_d      = mode_q;
    pos_d       = pos_q;
    fbb_d       = fbb_q;
    bnd_o       = '0;
    res_o       = '0;
    start       = 1'b0;
    mode_gather = 1'b0;
    fbb_eff     = fbb_q;
    idx         = pos_q;

    unique case (mode_q)
      ModeIdle:   start = 1'b1;
      ModeSkip:   start = is_sync;
      ModePass:   mode_gather = 1'b0;
      ModeGather: mode_gather = 1'b1;
      default:    start = 1'b1;
    endcase

    if (mode_q == ModeSkip && !is_sync) begin
      // Dropped byte; the end of the chunk returns to a packet start.
      if (left_i == 16'd1) begin
        mode_d = ModeIdle;
      end
    end else begin
      res_o.emit = 1'b1;
      if (start) begin
        idx = '0;
        if (left_i >= PktLenW) begin
          bnd_o.valid = 1'b1;
          bnd_o.ok    = is_sync;
          if (!is_sync) begin
            res_o.emit = 1'b0;
            mode_d     = ModeSkip;
          end else begin
            mode_d = ModePass;
          end
        end else begin
          fbb_eff     = !is_sync;
          fbb_d       = !is_sync;
          mode_gather = 1'b1;
          mode_d      = ModeGather;
        end
      end
      if (res_o.emit) begin
        res_o.idx = idx;
        pos_d     = idx + 8'd1;
        if (idx == PktLast) begin
          res_o.last = 1'b1;
          if (mode_gather) begin
            res_o.hbad  = fbb_eff;
            bnd_o.valid = 1'b1;
            bnd_o.ok    = !fbb_eff;
          end
          mode_d = ModeIdle;
          pos_d  = '0;
        end
      end
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      pos_q  <= '0;
      fbb_q  <= 1'b0;
    end else if (step_i) begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      fbb_q  <= fbb_d;
    end
  end

endmodule

// ===== rtl/core/tspa_lock_track.sv =====
// Lock tracker: good and bad boundary runs, lock flag and error counters.
// Depends on tspa_pkg; takes boundary events from tspa_align.
module tspa_lock_track import tspa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  boundary_t   bnd_i,
  input  track_cfg_t  cfg_i,
  output track_stat_t stat_o
);

  logic [3:0]  good_q, good_d;
  logic [3:0]  bad_q, bad_d;
  logic        after_bad_q, after_bad_d;
  logic        lock_q, lock_d;
  logic [31:0] err_q, err_d;
  logic [31:0] loss_q, loss_d;

  // Boundary accounting.
  always_comb begin
    good_d      = good_q;
    bad_d       = bad_q;
    after_bad_d = after_bad_q;
    lock_d      = lock_q;
    err_d       = err_q;
    loss_d      = loss_q;
    if (cfg_i.sync_enable && bnd_i.valid) begin
      if (!bnd_i.ok) begin
        err_d       = err_q + 32'd1;
        good_d      = '0;
        after_bad_d = 1'b1;
        if (bad_q < cfg_i.loss_threshold) begin
          bad_d = bad_q + 4'd1;
          if (bad_d == cfg_i.loss_threshold && lock_q) begin
            lock_d = 1'b0;
            loss_d = loss_q + 32'd1;
          end
        end
      end else if (after_bad_q) begin
        // The first good boundary after a bad one is not counted.
        after_bad_d = 1'b0;
      end else begin
        bad_d = '0;
        if (good_q < cfg_i.lock_threshold) begin
          good_d = good_q + 4'd1;
          if (good_d == cfg_i.lock_threshold) begin
            lock_d = 1'b1;
          end
        end
      end
    end
  end

  assign stat_o.locked   = lock_d;
  assign stat_o.err_cnt  = err_d;
  assign stat_o.loss_cnt = loss_d;

  // Tracking registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      good_q      <= '0;
      bad_q       <= '0;
      after_bad_q <= 1'b0;
      lock_q      <= 1'b0;
      err_q       <= '0;
      loss_q      <= '0;
    end else if (step_i) begin
      good_q      <= good_d;
      bad_q       <= bad_d;
      after_bad_q <= after_bad_d;
      lock_q      <= lock_d;
      err_q       <= err_d;
      loss_q      <= loss_d;
    end
  end

endmodule

// ===== rtl/core/ts_packet_aligner_sync_tracker_top.sv =====
// A held byte steps into the output register once the output slot frees. Throughput:
// one byte per cycle while m_axis_tready_i holds; input register, single-pass step
// logic and an output register let a new request enter while a result waits if the
// input register is empty. Skipped bytes produce no output. Reset is asynchronous and
// active low; it returns the aligner to a packet start, clears tracking and loads
// defaults. Top level: APB config registers, input and output stages; uses tspa_pkg.
module ts_packet_aligner_sync_tracker_top import tspa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // [7:0] data_byte, [23:8] bytes_left
  // Output stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] out_byte, [15:8] byte_index, [16] locked, [48:17] sync_error_count,
  // [80:49] sync_loss_count, [87:81] zero
  output logic [87:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,  // packet_last
  output logic        m_axis_tuser_o,  // [0] header_bad
  // Configuration port.
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  track_cfg_t  cfg_q;
  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic [15:0] in_left_q;
  logic        out_valid_q, out_valid_d;
  logic [87:0] out_data_q;
  logic        out_last_q;
  logic        out_user_q;

  logic        out_free;
  logic        step;
  logic        cfg_wr;
  boundary_t   bnd;
  align_res_t  res;
  track_stat_t stat;

  // Configuration registers.
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_enable    <= SyncEnableRst;
      cfg_q.lock_threshold <= LockThresholdRst;
      cfg_q.loss_threshold <= LossThresholdRst;
    end else if (cfg_wr) begin
      unique case (paddr_i[3:2])
        RegSyncEnable:    cfg_q.sync_enable    <= pwdata_i[0];
        RegLockThreshold: cfg_q.lock_threshold <= pwdata_i[3:0];
        RegLossThreshold: cfg_q.loss_threshold <= pwdata_i[3:0];
        default:          cfg_q.sync_enable    <= cfg_q.sync_enable;
      endcase
    end
  end

  always_comb begin
    unique case (paddr_i[3:2])
      RegSyncEnable:    prdata_o = {31'd0, cfg_q.sync_enable};
      RegLockThreshold: prdata_o = {28'd0, cfg_q.lock_threshold};
      RegLossThreshold: prdata_o = {28'd0, cfg_q.loss_threshold};
      default:          prdata_o = '0;
    endcase
  end

  // Handshake: the step runs when a byte is held and the output slot frees.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign step            = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i[7:0];
      in_left_q <= s_axis_tdata_i[23:8];
    end
  end

  tspa_align u_align (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .left_i (in_left_q),
    .bnd_o  (bnd),
    .res_o  (res)
  );

  tspa_lock_track u_track (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .bnd_i  (bnd),
    .cfg_i  (cfg_q),
    .stat_o (stat)
  );

  // Output register.
  always_comb begin
    if (step) begin
      out_valid_d = res.emit;
    end else begin
      out_valid_d = out_valid_q && !m_axis_tready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res.emit) begin
      out_data_q <= {7'd0, stat.loss_cnt, stat.err_cnt, stat.locked, res.idx, in_byte_q};
      out_last_q <= res.last;
      out_user_q <= res.hbad;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule
